>>> rtl/core/ntsc_pkg.sv
// Shared types, codes and constants of the normalized text stream compare block.
package ntsc_pkg;

  // Character codes used by the filters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  // Filter mode register codes
  localparam logic [1:0] FILTER_NO_WS    = 2'd0;
  localparam logic [1:0] FILTER_EOL      = 2'd1;
  localparam logic [1:0] FILTER_NO_BLANK = 2'd2;
  localparam logic [1:0] FILTER_EXACT    = 2'd3;

  // Request kinds on the input tuser
  localparam logic [1:0] MODE_BYTE_A = 2'd0;
  localparam logic [1:0] MODE_BYTE_B = 2'd1;
  localparam logic [1:0] MODE_END_A  = 2'd2;
  localparam logic [1:0] MODE_END_B  = 2'd3;

  // Sizes
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int OPQ_DEPTH      = 4;
  localparam int OUT_TDATA_W    = 40;

  // One classified request handed from the front to the back
  typedef struct packed {
    logic       has_sym;
    logic       side;
    logic [7:0] sym;
    logic       done;
  } sym_op_t;

  // One result as held in the output register
  typedef struct packed {
    logic        done;
    logic        equal;
    logic        mismatch;
    logic        overflow;
    logic [31:0] count;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

>>> rtl/core/normalized_text_stream_compare.sv
// Top level of the normalized text stream compare block.
// Takes one request per cycle sustained and returns exactly one result per
// request, in order. A request is filtered in the cycle it is accepted and
// enters a four-entry queue; while results are taken, the back end takes one
// queued request per cycle, does at most one push or one compare-and-pop on
// the lead FIFO (a single-port read of the FIFO head), and registers the
// result, so a result passes the queue and then the result register. The input
// stalls only when the queue is full because results are not being taken.
module normalized_text_stream_compare import ntsc_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // byte_value
  input  logic [1:0]             s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // equal, mismatch_seen, overflow,
                                            // matched_count[31:0], zero pad
  output logic                   m_tlast,   // done_res
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_data   // filter_mode
);

  logic       filter_mode;
  logic [1:0] filter_mode_q;
  logic       in_take;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  sym_op_t    front_op;
  sym_op_t    q_op;
  result_t    res;

  assign cfg_ready   = 1'b1;
  assign s_tready    = !q_full;
  assign in_take     = s_tvalid && s_tready;
  assign filter_mode = cfg_valid;

  // Filter mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode_q <= FILTER_EXACT;
    end else if (filter_mode && cfg_ready) begin
      filter_mode_q <= cfg_data;
    end
  end

  ntsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode_q),
    .take        (in_take),
    .mode        (s_tuser),
    .byte_value  (s_tdata),
    .op          (front_op)
  );

  ntsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_take),
    .push_op  (front_op),
    .full     (q_full),
    .pop      (q_pop),
    .op_valid (q_valid),
    .op       (q_op)
  );

  ntsc_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (q_op),
    .op_pop    (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // Output packing
  assign m_tlast = res.done;
  assign m_tdata = {{(OUT_TDATA_W - 35){1'b0}}, res.count, res.overflow,
                    res.mismatch, res.equal};

endmodule

>>> rtl/core/ntsc_front.sv
// Front end: classifies each request through the filter and tracks stream ends.
module ntsc_front import ntsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] filter_mode,
  input  logic       take,
  input  logic [1:0] mode,
  input  logic [7:0] byte_value,
  output sym_op_t    op
);

  logic [1:0] ended, ended_next;
  logic [1:0] pending_cr, pending_cr_next;
  logic       s;

  assign s = mode[0];

  // Filter and end tracking
  always_comb begin
    ended_next      = ended;
    pending_cr_next = pending_cr;
    op.has_sym      = 1'b0;
    op.side         = s;
    op.sym          = byte_value;
    op.done         = 1'b0;
    unique case (mode)
      MODE_BYTE_A, MODE_BYTE_B: begin
        if (!ended[s]) begin
          unique case (filter_mode)
            FILTER_NO_WS: begin
              op.has_sym = !is_blank(byte_value) && (byte_value != CH_CR) &&
                           (byte_value != CH_LF);
            end
            FILTER_EOL: begin
              if (byte_value == CH_CR) begin
                pending_cr_next[s] = 1'b1;
                op.has_sym         = 1'b1;
                op.sym             = CH_LF;
              end else if (byte_value == CH_LF) begin
                if (pending_cr[s]) begin
                  pending_cr_next[s] = 1'b0;
                end else begin
                  op.has_sym = 1'b1;
                end
              end else begin
                pending_cr_next[s] = 1'b0;
                op.has_sym         = 1'b1;
              end
            end
            FILTER_NO_BLANK: begin
              op.has_sym = !is_blank(byte_value);
            end
            default: begin
              op.has_sym = 1'b1;
            end
          endcase
        end
      end
      MODE_END_A, MODE_END_B: begin
        ended_next[s] = 1'b1;
        if (&ended_next) begin
          op.done         = 1'b1;
          ended_next      = '0;
          pending_cr_next = '0;
        end
      end
      default: begin
        op.has_sym = 1'b0;
      end
    endcase
  end

  // Per-stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      ended      <= '0;
      pending_cr <= '0;
    end else if (take) begin
      ended      <= ended_next;
      pending_cr <= pending_cr_next;
    end
  end

endmodule

>>> rtl/core/ntsc_queue.sv
// Short queue of classified requests between the front and the back.
module ntsc_queue import ntsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sym_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    op_valid,
  output sym_op_t op
);

  localparam int PW = $clog2(OPQ_DEPTH);
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  sym_op_t       slots [OPQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(OPQ_DEPTH));
  assign op_valid = (count != '0);
  assign op       = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/ntsc_back.sv
// Back end: lead FIFO, compare against its head, sticky flags and result register.
module ntsc_back import ntsc_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  sym_op_t op,
  output logic    op_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = $clog2(2 * FIFO_DEPTH);

  logic [7:0]    lead_fifo [FIFO_DEPTH];
  logic [7:0]    rd_data;
  logic          byp_valid;
  logic [7:0]    byp_data;
  logic [7:0]    head;

  logic [CW-1:0] fifo_count, fifo_count_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic          lead_side, lead_side_next;
  logic          mismatch, mismatch_next;
  logic          overflow, overflow_next;
  logic [31:0]   matched, matched_next;
  logic          push;
  logic [SW-1:0] wr_sum;
  logic [AW-1:0] wr_addr;
  result_t       res_next;

  assign op_pop = op_valid && (!out_valid || out_ready);
  assign head   = byp_valid ? byp_data : rd_data;

  // Write slot behind the current tail
  assign wr_sum  = SW'(rd_ptr) + SW'(fifo_count);
  assign wr_addr = (wr_sum >= SW'(FIFO_DEPTH)) ? AW'(wr_sum - SW'(FIFO_DEPTH))
                                               : AW'(wr_sum);

  // Push, or compare and pop
  always_comb begin
    push            = 1'b0;
    fifo_count_next = fifo_count;
    rd_ptr_next     = rd_ptr;
    lead_side_next  = lead_side;
    mismatch_next   = mismatch;
    overflow_next   = overflow;
    matched_next    = matched;
    if (op_pop && op.has_sym) begin
      if ((fifo_count == '0) || (lead_side == op.side)) begin
        if (fifo_count == CW'(FIFO_DEPTH)) begin
          overflow_next = 1'b1;
        end else begin
          push            = 1'b1;
          fifo_count_next = fifo_count + CW'(1);
          lead_side_next  = op.side;
        end
      end else begin
        if (head == op.sym) begin
          if (matched != '1) begin
            matched_next = matched + 32'd1;
          end
        end else begin
          mismatch_next = 1'b1;
        end
        rd_ptr_next     = (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
        fifo_count_next = fifo_count - CW'(1);
      end
    end
    res_next.done     = op.done;
    res_next.equal    = op.done && !mismatch_next && !overflow_next &&
                        (fifo_count_next == '0);
    res_next.mismatch = mismatch_next;
    res_next.overflow = overflow_next;
    res_next.count    = matched_next;
    // Verdict clears the comparison state
    if (op_pop && op.done) begin
      fifo_count_next = '0;
      rd_ptr_next     = '0;
      lead_side_next  = 1'b0;
      mismatch_next   = 1'b0;
      overflow_next   = 1'b0;
      matched_next    = '0;
    end
  end

  // Lead FIFO memory with registered head read
  always_ff @(posedge clk) begin
    if (push) begin
      lead_fifo[wr_addr] <= op.sym;
    end
    rd_data  <= lead_fifo[rd_ptr_next];
    byp_data <= op.sym;
  end

  // Comparison state
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid  <= 1'b0;
      fifo_count <= '0;
      rd_ptr     <= '0;
      lead_side  <= 1'b0;
      mismatch   <= 1'b0;
      overflow   <= 1'b0;
      matched    <= '0;
    end else begin
      byp_valid  <= push && (wr_addr == rd_ptr_next);
      fifo_count <= fifo_count_next;
      rd_ptr     <= rd_ptr_next;
      lead_side  <= lead_side_next;
      mismatch   <= mismatch_next;
      overflow   <= overflow_next;
      matched    <= matched_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/core/ntsc_checker.sv
// Port-level checks of the normalized text stream compare block, bound to the top level.
module ntsc_checker import ntsc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Equal verdict only on the final result
  a_eq_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[0])
    else $error("equal set before both streams ended");

  // Equal verdict excludes sticky errors
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[2])
    else $error("equal set with mismatch or overflow");

  // Padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:35] == '0)
    else $error("tdata padding not zero");

endmodule

bind normalized_text_stream_compare ntsc_checker u_ntsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/normalized_text_stream_compare_test.sv
// Self-checking stream testbench for the normalized text stream compare block.
module normalized_text_stream_compare_test import ntsc_pkg::*;;

  localparam int IDLE_PCT   = 33;
  localparam int HOLD_LEN   = 80;
  localparam int STALL_MAX  = 2000;
  localparam int RAND_ITEMS = 1600;
  localparam int PHASE_LEN  = 200;
  localparam int LEAD_AW    = $clog2(FIFO_DEPTH_DEF);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } text_req_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_data = '0;

  normalized_text_stream_compare i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Requests waiting for the driver, and the verdicts they should produce
  text_req_t  text_reqs[$];
  result_t    pending_verdicts[$];
  logic [7:0] text_a[$];
  logic [7:0] text_b[$];

  int  n_pushed = 0, n_ignored = 0, n_taken = 0, n_results = 0, n_fail = 0;
  int  n_verdicts = 0, n_equal = 0, n_mism = 0, n_ovf = 0, n_cfg = 0;
  int  holds_asked = 0, holds_served = 0, hold_left = 0, stall_cycles = 0;
  bit  req_taken = 1'b0;
  bit  steady = 1'b0;
  logic [31:0] max_count = '0;

  // ---------------------------------------------------------------------------
  // Predictor: normalizes both streams and tracks the lead FIFO
  // ---------------------------------------------------------------------------
  logic [1:0]  filter_sel;
  logic [7:0]  lead_syms[FIFO_DEPTH_DEF];
  int unsigned lead_cnt, lead_rd;
  logic        lead_who;
  logic [1:0]  cr_open, ended;
  logic        mm_flag, ov_flag;
  logic [31:0] match_cnt;

  function automatic logic is_spacing(input logic [7:0] c);
    case (c)
      CH_SP, CH_TAB, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_streams();
    lead_cnt  = 0;
    lead_rd   = 0;
    lead_who  = 1'b0;
    cr_open   = '0;
    ended     = '0;
    mm_flag   = 1'b0;
    ov_flag   = 1'b0;
    match_cnt = '0;
  endfunction

  // Either queue the symbol of the lead side or compare it against the head
  function automatic void feed_symbol(input logic s, input logic [7:0] sym);
    if (lead_cnt == 0 || lead_who == s) begin
      if (lead_cnt >= FIFO_DEPTH_DEF) begin
        ov_flag = 1'b1;
      end else begin
        lead_syms[LEAD_AW'((lead_rd + lead_cnt) % FIFO_DEPTH_DEF)] = sym;
        lead_cnt++;
        lead_who = s;
      end
    end else begin
      if (lead_syms[LEAD_AW'(lead_rd)] == sym) begin
        if (match_cnt != '1) match_cnt++;
      end else begin
        mm_flag = 1'b1;
      end
      lead_rd = (lead_rd + 1) % FIFO_DEPTH_DEF;
      lead_cnt--;
    end
  endfunction

  function automatic void filter_byte(input logic s, input logic [7:0] c);
    case (filter_sel)
      FILTER_NO_WS: begin
        if (!is_spacing(c) && c != CH_CR && c != CH_LF) feed_symbol(s, c);
      end
      FILTER_EOL: begin
        if (c == CH_CR) begin
          cr_open[s] = 1'b1;
          feed_symbol(s, CH_LF);
        end else if (c == CH_LF) begin
          // LF right after CR belongs to the same line break
          if (cr_open[s]) cr_open[s] = 1'b0;
          else feed_symbol(s, CH_LF);
        end else begin
          cr_open[s] = 1'b0;
          feed_symbol(s, c);
        end
      end
      FILTER_NO_BLANK: begin
        if (!is_spacing(c)) feed_symbol(s, c);
      end
      default: feed_symbol(s, c);
    endcase
  endfunction

  function automatic result_t next_verdict(input logic [1:0] kind, input logic [7:0] c);
    result_t r;
    logic    s;
    s = kind[0];
    if (kind == MODE_BYTE_A || kind == MODE_BYTE_B) begin
      if (!ended[s]) filter_byte(s, c);
    end else begin
      ended[s] = 1'b1;
    end
    r.done     = 1'b0;
    r.equal    = 1'b0;
    r.mismatch = mm_flag;
    r.overflow = ov_flag;
    r.count    = match_cnt;
    // Both streams closed: verdict, then the compare starts over
    if (ended == 2'b11) begin
      r.done  = 1'b1;
      r.equal = !mm_flag && !ov_flag && lead_cnt == 0;
      clear_streams();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on accepted requests, checks accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    bit      moved;
    req_taken = 1'b0;
    moved     = 1'b0;
    if (rst) begin
      filter_sel = FILTER_EXACT;
      clear_streams();
    end else begin
      if (cfg_valid && cfg_ready) begin
        filter_sel = cfg_data;
        n_cfg++;
        moved = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        pending_verdicts.push_back(next_verdict(s_tuser, s_tdata));
        req_taken = 1'b1;
        n_taken++;
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        n_results++;
        if (pending_verdicts.size() == 0) begin
          $error("result with no request outstanding");
          n_fail++;
        end else begin
          exp_r = pending_verdicts.pop_front();
          check_field("done_res", 32'(exp_r.done), 32'(m_tlast));
          check_field("equal", 32'(exp_r.equal), 32'(m_tdata[0]));
          check_field("mismatch_seen", 32'(exp_r.mismatch), 32'(m_tdata[1]));
          check_field("overflow", 32'(exp_r.overflow), 32'(m_tdata[2]));
          check_field("matched_count", exp_r.count, m_tdata[34:3]);
          check_field("tdata pad", '0, 32'(m_tdata[OUT_TDATA_W-1:35]));
          if (exp_r.count > max_count) max_count = exp_r.count;
          if (exp_r.done) begin
            n_verdicts++;
            if (exp_r.equal) n_equal++;
            if (exp_r.mismatch) n_mism++;
            if (exp_r.overflow) n_ovf++;
          end
        end
      end
      // Watchdog on a stuck handshake
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("timeout: no transfer for %0d cycles", STALL_MAX);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    text_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_taken) begin
      // hold the offered request until it is taken
    end else if (text_reqs.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
      nxt = text_reqs.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= nxt.kind;
      s_tdata  <= nxt.value;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_req(input logic [1:0] kind, input logic [7:0] value);
    text_reqs.push_back('{kind: kind, value: value});
    n_pushed++;
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // Line break styles: 0 LF, 1 CR LF, 2 CR alone
  function automatic void put_newline(input int s, input int style);
    if (style != 0) begin
      if (s == 0) text_a.push_back(CH_CR);
      else text_b.push_back(CH_CR);
    end
    if (style != 2) begin
      if (s == 0) text_a.push_back(CH_LF);
      else text_b.push_back(CH_LF);
    end
  endfunction

  task automatic write_filter(input logic [1:0] fm);
    int seen;
    seen = n_cfg;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fm;
    do @(negedge clk); while (n_cfg == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_taken != n_pushed || pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Two texts that mostly normalize to the same symbols, interleaved and closed, or a run of random noise requests
  task automatic add_text_pair(input logic [1:0] fm);
    int         ntok, style, pick_a, pick_b, ia, ib;
    bit         cr_a, cr_b;
    logic [7:0] c;
    logic [1:0] first_end, other_end;
    text_a.delete();
    text_b.delete();
    style = $urandom_range(0, 99);
    // Noise: any request kind, any byte
    if (style < 12) begin
      repeat ($urandom_range(1, 12))
        add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      return;
    end
    ntok = (style < 20) ? $urandom_range(18, 26) : $urandom_range(2, 14);
    cr_a = 1'b0;
    cr_b = 1'b0;
    for (int i = 0; i < ntok; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          c = 8'($urandom_range(0, 255));
          if (is_spacing(c) || c == CH_CR || c == CH_LF) c = c ^ 8'h80;
          text_a.push_back(c);
          text_b.push_back(c);
          cr_a = 1'b0;
          cr_b = 1'b0;
        end
        6, 7: begin
          if (fm == FILTER_NO_WS || fm == FILTER_NO_BLANK) begin
            repeat ($urandom_range(0, 3)) text_a.push_back(any_blank());
            repeat ($urandom_range(0, 3)) text_b.push_back(any_blank());
          end else begin
            c = any_blank();
            text_a.push_back(c);
            text_b.push_back(c);
          end
          cr_a = 1'b0;
          cr_b = 1'b0;
        end
        default: begin
          pick_a = $urandom_range(0, 2);
          pick_b = (fm == FILTER_EOL || fm == FILTER_NO_WS) ? $urandom_range(0, 2) : pick_a;
          // a lone CR followed by a lone LF would merge into one break
          if (cr_a && pick_a == 0) pick_a = 1;
          if (cr_b && pick_b == 0) pick_b = 1;
          put_newline(0, pick_a);
          put_newline(1, pick_b);
          cr_a = (pick_a == 2);
          cr_b = (pick_b == 2);
        end
      endcase
    end
    // Occasional differences: a flipped bit or a longer first text
    if ($urandom_range(0, 99) < 20 && text_b.size() > 0) begin
      ia = $urandom_range(0, text_b.size() - 1);
      text_b[ia] = text_b[ia] ^ (8'h01 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 99) < 10)
      repeat ($urandom_range(1, 3)) text_a.push_back(8'($urandom_range(8'h41, 8'h5A)));
    // Interleave; the long texts go first-stream-first to run past the FIFO
    ia = 0;
    ib = 0;
    while (ia < text_a.size() || ib < text_b.size()) begin
      if (ib >= text_b.size() ||
          (ia < text_a.size() && (style < 20 || $urandom_range(0, 1) == 1))) begin
        add_req(MODE_BYTE_A, text_a[ia]);
        ia++;
      end else begin
        add_req(MODE_BYTE_B, text_b[ib]);
        ib++;
      end
    end
    // Close both streams, sometimes with a late byte or a repeated end
    first_end = ($urandom_range(0, 1) == 1) ? MODE_END_A : MODE_END_B;
    other_end = (first_end == MODE_END_A) ? MODE_END_B : MODE_END_A;
    add_req(first_end, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 10) begin
      add_req((first_end == MODE_END_A) ? MODE_BYTE_A : MODE_BYTE_B,
              8'($urandom_range(0, 255)));
      n_ignored++;
    end
    if ($urandom_range(0, 99) < 10) begin
      add_req(first_end, 8'($urandom_range(0, 255)));
      n_ignored++;
    end
    add_req(other_end, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [1:0] fm;
    int         phase_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Exact compare at the reset setting: extremes, a mismatch, late byte, double end
    add_req(MODE_BYTE_A, 8'h00);
    add_req(MODE_BYTE_B, 8'h00);
    add_req(MODE_BYTE_A, 8'hFF);
    add_req(MODE_BYTE_B, 8'hFF);
    add_req(MODE_BYTE_A, 8'h41);
    add_req(MODE_BYTE_B, 8'h42);
    add_req(MODE_END_A, 8'h00);
    add_req(MODE_BYTE_A, 8'h55);
    add_req(MODE_END_A, 8'hFF);
    add_req(MODE_BYTE_B, 8'h7E);
    add_req(MODE_END_B, 8'h00);
    wait_drained();

    // Line endings folded; leaves a CR pending on the first stream
    write_filter(FILTER_EOL);
    add_req(MODE_BYTE_A, CH_CR);
    add_req(MODE_BYTE_A, CH_LF);
    add_req(MODE_BYTE_B, CH_LF);
    add_req(MODE_BYTE_A, CH_CR);
    wait_drained();

    // Filter switched mid-stream
    write_filter(FILTER_NO_BLANK);
    add_req(MODE_BYTE_A, CH_LF);
    add_req(MODE_BYTE_B, CH_CR);
    add_req(MODE_BYTE_B, CH_LF);
    add_req(MODE_END_B, 8'h00);
    add_req(MODE_END_A, 8'h00);
    wait_drained();

    // All whitespace dropped
    write_filter(FILTER_NO_WS);
    add_req(MODE_BYTE_A, CH_SP);
    add_req(MODE_BYTE_A, CH_TAB);
    add_req(MODE_BYTE_A, 8'h61);
    add_req(MODE_BYTE_B, CH_VT);
    add_req(MODE_BYTE_B, CH_FF);
    add_req(MODE_BYTE_B, CH_CR);
    add_req(MODE_BYTE_B, 8'h61);
    add_req(MODE_BYTE_A, CH_LF);
    add_req(MODE_END_A, 8'h00);
    add_req(MODE_END_B, 8'h00);
    wait_drained();

    // Random phases, each under its own filter setting
    phase_start = n_pushed - n_ignored;
    for (int ph = 0; n_pushed - n_ignored - phase_start < RAND_ITEMS; ph++) begin
      case (ph % 4)
        0: fm = FILTER_NO_WS;
        1: fm = FILTER_EXACT;
        2: fm = FILTER_EOL;
        default: fm = FILTER_NO_BLANK;
      endcase
      if (ph >= 4) fm = 2'($urandom_range(0, 3));
      write_filter(fm);
      steady = (ph == 2 || ph == 4);
      // receiver backs off while the sender keeps offering
      if (ph == 4) holds_asked++;
      for (int k = n_pushed - n_ignored; n_pushed - n_ignored - k < PHASE_LEN; )
        add_text_pair(fm);
      wait_drained();
      steady = 1'b0;
    end

    repeat (8) @(negedge clk);
    $display("Run covered %0d requests and %0d results over %0d filter writes.",
             n_pushed, n_results, n_cfg);
    $display("Verdicts: %0d total, %0d equal, %0d mismatched, %0d overflowed; top count %0d.",
             n_verdicts, n_equal, n_mism, n_ovf, max_count);
    if (n_fail == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ntsc_pkg.sv
rtl/core/ntsc_front.sv
rtl/core/ntsc_queue.sv
rtl/core/ntsc_back.sv
rtl/core/normalized_text_stream_compare.sv
rtl/core/ntsc_checker.sv
tb/normalized_text_stream_compare_test.sv
